// ===== hw/rtl/rdft_pkg.sv =====
// Shared types and constants for the real-input DFT core.
// Holds field widths, the MAC control struct and twiddle-series constants.
// No dependencies.
package rdft_pkg;

	localparam int SAMPLE_W = 16;
	localparam int TW_W     = 16;
	localparam int PROD_W   = 32;
	localparam int ACC_W    = 38;
	localparam int RES_W    = 23;
	localparam int BIN_W    = 6;
	localparam int FRAC_W   = 15;

	// Twiddle generation: Q30 quarter-turn angle and Taylor term divisors
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint          ONE_Q30     = 64'sd1073741824;
	localparam longint unsigned COS_DIV [9] = '{2, 12, 30, 56, 90, 132, 182, 240, 306};
	localparam longint unsigned SIN_DIV [9] = '{6, 20, 42, 72, 110, 156, 210, 272, 342};

	typedef struct packed {
		logic             vld;
		logic             first;  // first sample of a bin
		logic             last;   // last sample of a bin
		logic             fin;    // final bin of the frame
		logic [BIN_W-1:0] bin;
	} mac_ctl_t;

	// Q30 to Q15 with rounding, clamped to the non-negative part of the Q1.15 range
	function automatic longint q30_to_q15(input longint v);
		longint r;
		r = (v < 0) ? 64'sd0 : v;
		r = (r + 64'sd16384) >>> 15;
		if (r > 64'sd32767)
			r = 64'sd32767;
		return r;
	endfunction

endpackage

// ===== hw/rtl/rdft_mac.sv =====
// Shared complex MAC pair: two 16x16 multipliers, two accumulators, rounding.
// Depends on rdft_pkg for widths and the control struct.
module rdft_mac
	import rdft_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  mac_ctl_t                   ctl_s1,
	input  logic signed [SAMPLE_W-1:0] sample_s1,
	input  logic signed [TW_W-1:0]     cos_s1,
	input  logic signed [TW_W-1:0]     nsin_s1,
	output logic                       valid_q,
	output logic [BIN_W-1:0]           bin_q,
	output logic                       last_q,
	output logic signed [RES_W-1:0]    re_q,
	output logic signed [RES_W-1:0]    im_q
);

	mac_ctl_t                 ctl_s2;
	logic signed [PROD_W-1:0] prod_re_s2;
	logic signed [PROD_W-1:0] prod_im_s2;
	logic signed [ACC_W-1:0]  acc_re_q;
	logic signed [ACC_W-1:0]  acc_im_q;
	logic                     dump_s3;
	logic [BIN_W-1:0]         bin_s3;
	logic                     fin_s3;
	logic signed [ACC_W-1:0]  rnd_re;
	logic signed [ACC_W-1:0]  rnd_im;

	always_ff @(posedge clk) begin
		prod_re_s2 <= sample_s1 * cos_s1;
		prod_im_s2 <= sample_s1 * nsin_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2  <= '0;
			dump_s3 <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			ctl_s2  <= ctl_s1;
			dump_s3 <= ctl_s2.vld & ctl_s2.last;
			valid_q <= dump_s3;
		end
	end

	// restart the sums on the first sample of each bin
	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			acc_re_q <= ctl_s2.first ? ACC_W'(prod_re_s2) : acc_re_q + ACC_W'(prod_re_s2);
			acc_im_q <= ctl_s2.first ? ACC_W'(prod_im_s2) : acc_im_q + ACC_W'(prod_im_s2);
			bin_s3   <= ctl_s2.bin;
			fin_s3   <= ctl_s2.fin;
		end
	end

	assign rnd_re = acc_re_q + (ACC_W'(1) << (FRAC_W - 1));
	assign rnd_im = acc_im_q + (ACC_W'(1) << (FRAC_W - 1));

	always_ff @(posedge clk) begin
		if (dump_s3) begin
			re_q   <= rnd_re[FRAC_W +: RES_W];
			im_q   <= rnd_im[FRAC_W +: RES_W];
			bin_q  <= bin_s3;
			last_q <= fin_s3;
		end
	end

endmodule

// ===== hw/rtl/real_input_dft_core.sv =====
// Real-input DFT core: frame store, bin/sample sequencer, twiddle ROM.
// Depends on rdft_pkg and rdft_mac.
//
// Samples are written one per transfer (start high while busy is low) into a
// FRAME_LENGTH-deep store. The transfer of the last sample of a frame raises
// busy, and one complex MAC pair then walks all FRAME_LENGTH samples for each
// bin 0..FRAME_LENGTH/2, one sample per cycle. Busy stays high until the final
// bin has gone out; bin k is presented on result_valid for one cycle, after
// bin k-1, and the final bin carries last_bin. The single MAC pair thus sets
// the frame rate: no new frame is taken while busy. Results are not held: the
// receiver must take each one in the cycle it is shown.
module real_input_dft_core
	import rdft_pkg::*;
#(
	parameter int FRAME_LENGTH = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       result_valid,
	output logic [BIN_W-1:0]           bin_index,
	output logic signed [RES_W-1:0]    real_part,
	output logic signed [RES_W-1:0]    imag_part,
	output logic                       last_bin
);

	localparam int NUM_BINS = FRAME_LENGTH / 2 + 1;
	localparam int AW       = $clog2(FRAME_LENGTH);
	localparam int KW       = $clog2(NUM_BINS);

	localparam logic [1:0] ST_FILL  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	// Twiddle for index m of the frame, Q1.15; sel_sin returns -sin
	function automatic logic signed [TW_W-1:0] tw_calc(input int m, input bit sel_sin);
		longint unsigned quad;
		longint unsigned rem;
		longint unsigned theta;
		longint unsigned t2;
		longint unsigned term;
		longint          c;
		longint          s;
		longint          cq;
		longint          sq;
		longint          cv;
		longint          sv;
		quad  = longint'(4 * m) / FRAME_LENGTH;
		rem   = longint'(4 * m) - quad * FRAME_LENGTH;
		theta = (HALF_PI_Q30 * rem + FRAME_LENGTH / 2) / FRAME_LENGTH;
		t2    = (theta * theta + (64'd1 << 29)) >> 30;
		c     = ONE_Q30;
		s     = longint'(theta);
		term  = longint'(ONE_Q30);
		for (int i = 0; i < 9; i++) begin
			term = ((term * t2) >> 30) / COS_DIV[i];
			c = (i % 2 == 0) ? c - longint'(term) : c + longint'(term);
		end
		term = theta;
		for (int i = 0; i < 9; i++) begin
			term = ((term * t2) >> 30) / SIN_DIV[i];
			s = (i % 2 == 0) ? s - longint'(term) : s + longint'(term);
		end
		cq = q30_to_q15(c);
		sq = q30_to_q15(s);
		case (quad & 64'd3)
			64'd0:   begin cv = cq;  sv = sq;  end
			64'd1:   begin cv = -sq; sv = cq;  end
			64'd2:   begin cv = -cq; sv = -sq; end
			default: begin cv = sq;  sv = -cq; end
		endcase
		return sel_sin ? TW_W'(-sv) : TW_W'(cv);
	endfunction

	function automatic logic [FRAME_LENGTH*TW_W-1:0] build_rom(input bit sel_sin);
		logic [FRAME_LENGTH*TW_W-1:0] rom;
		rom = '0;
		for (int m = 0; m < FRAME_LENGTH; m++)
			rom[m*TW_W +: TW_W] = tw_calc(m, sel_sin);
		return rom;
	endfunction

	localparam logic [FRAME_LENGTH*TW_W-1:0] COS_ROM  = build_rom(1'b0);
	localparam logic [FRAME_LENGTH*TW_W-1:0] NSIN_ROM = build_rom(1'b1);

	logic [1:0]                 state_q;
	logic [AW-1:0]              fill_q;
	logic [AW-1:0]              t_q;
	logic [AW-1:0]              m_q;
	logic [KW-1:0]              k_q;
	logic [AW:0]                m_sum;
	logic [AW-1:0]              m_nxt;
	logic                       wr_en;
	logic                       issue;
	logic                       t_last;
	logic                       k_last;
	logic signed [SAMPLE_W-1:0] store [FRAME_LENGTH];
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [TW_W-1:0]     cos_s1;
	logic signed [TW_W-1:0]     nsin_s1;
	mac_ctl_t                   ctl_s1;

	assign busy   = (state_q != ST_FILL);
	assign wr_en  = start & ~busy;
	assign issue  = (state_q == ST_RUN);
	assign t_last = (t_q == AW'(FRAME_LENGTH - 1));
	assign k_last = (k_q == KW'(NUM_BINS - 1));

	// twiddle index advances by k each sample, modulo the frame length
	assign m_sum = {1'b0, m_q} + (AW+1)'(k_q);
	assign m_nxt = (m_sum >= (AW+1)'(FRAME_LENGTH)) ?
		AW'(m_sum - (AW+1)'(FRAME_LENGTH)) : AW'(m_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
			fill_q  <= '0;
			t_q     <= '0;
			m_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_FILL: begin
					if (wr_en) begin
						if (fill_q == AW'(FRAME_LENGTH - 1)) begin
							fill_q  <= '0;
							t_q     <= '0;
							m_q     <= '0;
							k_q     <= '0;
							state_q <= ST_RUN;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_RUN: begin
					if (t_last) begin
						t_q <= '0;
						m_q <= '0;
						if (k_last)
							state_q <= ST_DRAIN;
						else
							k_q <= k_q + 1'b1;
					end else begin
						t_q <= t_q + 1'b1;
						m_q <= m_nxt;
					end
				end
				ST_DRAIN: begin
					// hold busy until the final bin has gone out
					if (result_valid && last_bin)
						state_q <= ST_FILL;
				end
				default: state_q <= ST_FILL;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			store[fill_q] <= sample;
		sample_s1 <= store[t_q];
		cos_s1    <= COS_ROM[m_q*TW_W +: TW_W];
		nsin_s1   <= NSIN_ROM[m_q*TW_W +: TW_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld   <= issue;
			ctl_s1.first <= (t_q == '0);
			ctl_s1.last  <= t_last;
			ctl_s1.fin   <= k_last;
			ctl_s1.bin   <= BIN_W'(k_q);
		end
	end

	rdft_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.sample_s1 (sample_s1),
		.cos_s1    (cos_s1),
		.nsin_s1   (nsin_s1),
		.valid_q   (result_valid),
		.bin_q     (bin_index),
		.last_q    (last_bin),
		.re_q      (real_part),
		.im_q      (imag_part)
	);

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result transfer outside a busy period");

	a_last_bin_index: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_bin |-> bin_index == BIN_W'(NUM_BINS - 1))
		else $error("last_bin flagged on the wrong bin");

	a_idle_after_frame: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_bin |=> !busy && !result_valid)
		else $error("core not idle after final bin");

	a_bin_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_bin |-> ##FRAME_LENGTH
		(result_valid && bin_index == BIN_W'($past(bin_index, FRAME_LENGTH) + 1'b1)))
		else $error("next bin not delivered one frame length later");

endmodule
